// File: hdl/ptq_pkg.sv
// shared types and codes for the priority task queue
`timescale 1ns / 1ps
`default_nettype none
package ptq_pkg;

	typedef enum logic [1:0] {
		KIND_ADD  = 2'd0,
		KIND_EXEC = 2'd1,
		KIND_VIEW = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		STS_ADDED    = 3'd0,
		STS_EXECUTED = 3'd1,
		STS_EMPTY    = 3'd2,
		STS_LISTED   = 3'd3,
		STS_FULL     = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_LAST,
		ST_COMMIT,
		ST_RESULT
	} state_t;

	localparam int PRI_W = 16;
	localparam int ID_W  = 16;
	localparam int TAG_W = 16;
	localparam int ENTRY_W = PRI_W + ID_W + TAG_W;

	typedef struct packed {
		logic start_op;
		logic load_quick;
		logic scan_clear;
		logic scan_step;
		logic commit;
		logic out_done;
	} ptq_cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
		logic scan_end;
		logic more;
	} ptq_sts_t;

endpackage
`default_nettype wire

// File: hdl/ptq_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module ptq_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule
`default_nettype wire

// File: hdl/ptq_ctrl.sv
// controller state machine for the priority task queue
`timescale 1ns / 1ps
`default_nettype none
module ptq_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [1:0]        kind,
	output logic                   out_valid,
	input  wire logic              out_ready,
	input  wire ptq_pkg::ptq_sts_t sts,
	output ptq_pkg::ptq_cmd_t      cmd
);

	ptq_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ptq_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			ptq_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.start_op = 1'b1;
					case (kind)
						ptq_pkg::KIND_ADD: begin
							if (sts.full) begin
								cmd.load_quick = 1'b1;
								state_d = ptq_pkg::ST_RESULT;
							end else begin
								cmd.scan_clear = 1'b1;
								state_d = ptq_pkg::ST_SCAN;
							end
						end
						ptq_pkg::KIND_EXEC, ptq_pkg::KIND_VIEW: begin
							if (sts.empty) begin
								cmd.load_quick = 1'b1;
								state_d = ptq_pkg::ST_RESULT;
							end else begin
								cmd.scan_clear = 1'b1;
								state_d = ptq_pkg::ST_SCAN;
							end
						end
						default: begin
							state_d = ptq_pkg::ST_IDLE;
						end
					endcase
				end
			end
			ptq_pkg::ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_end) begin
					state_d = ptq_pkg::ST_LAST;
				end
			end
			ptq_pkg::ST_LAST: begin
				state_d = ptq_pkg::ST_COMMIT;
			end
			ptq_pkg::ST_COMMIT: begin
				cmd.commit = 1'b1;
				state_d = ptq_pkg::ST_RESULT;
			end
			ptq_pkg::ST_RESULT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					cmd.out_done = 1'b1;
					if (sts.more) begin
						cmd.scan_clear = 1'b1;
						state_d = ptq_pkg::ST_SCAN;
					end else begin
						state_d = ptq_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ptq_pkg::ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

// File: hdl/ptq_dpath.sv
// datapath: slot store, sequential max search and result register
`timescale 1ns / 1ps
`default_nettype none
module ptq_dpath #(
	parameter int QUEUE_DEPTH = 16
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic [1:0]                  kind,
	input  wire logic signed [ptq_pkg::PRI_W-1:0] task_priority,
	input  wire logic [ptq_pkg::TAG_W-1:0]   task_tag,
	input  wire ptq_pkg::ptq_cmd_t           cmd,
	output ptq_pkg::ptq_sts_t                sts,
	output logic [2:0]                       status,
	output logic [ptq_pkg::ID_W-1:0]         task_id,
	output logic signed [ptq_pkg::PRI_W-1:0] task_priority_out,
	output logic [ptq_pkg::TAG_W-1:0]        task_tag_out,
	output logic                             last
);

	localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	// latched beat
	logic [1:0]                        kind_q;
	logic signed [ptq_pkg::PRI_W-1:0]  pri_in_q;
	logic [ptq_pkg::TAG_W-1:0]         tag_in_q;

	// slot bookkeeping
	logic [QUEUE_DEPTH-1:0] valid_q;
	logic [QUEUE_DEPTH-1:0] listed_q;
	logic [CW-1:0]          count_q;
	logic [CW-1:0]          listed_cnt_q;
	logic [ptq_pkg::ID_W-1:0] next_id_q;

	// scan
	logic [IW-1:0] idx_q;
	logic          rd_vld_s1;
	logic          cand_s1;
	logic          free_s1;
	logic [IW-1:0] idx_s1;

	logic                              best_vld_q;
	logic [IW-1:0]                     best_idx_q;
	logic signed [ptq_pkg::PRI_W-1:0]  best_pri_q;
	logic [ptq_pkg::ID_W-1:0]          best_id_q;
	logic [ptq_pkg::TAG_W-1:0]         best_tag_q;
	logic                              free_found_q;
	logic [IW-1:0]                     free_idx_q;

	// ram
	logic                          ram_we;
	logic [ptq_pkg::ENTRY_W-1:0]   ram_wdata;
	logic [ptq_pkg::ENTRY_W-1:0]   ram_rdata;
	logic signed [ptq_pkg::PRI_W-1:0] rd_pri;
	logic [ptq_pkg::ID_W-1:0]      rd_id;
	logic [ptq_pkg::TAG_W-1:0]     rd_tag;
	logic                          rd_beats;

	logic res_last_q;

	assign ram_we    = cmd.commit && (kind_q == ptq_pkg::KIND_ADD);
	assign ram_wdata = {pri_in_q, next_id_q, tag_in_q};

	ptq_ram #(
		.WIDTH(ptq_pkg::ENTRY_W),
		.DEPTH(QUEUE_DEPTH)
	) u_ram (
		.clk    (clk),
		.wr_en  (ram_we),
		.wr_addr(free_idx_q),
		.wr_data(ram_wdata),
		.rd_addr(idx_q),
		.rd_data(ram_rdata)
	);

	assign rd_pri = $signed(ram_rdata[ptq_pkg::ENTRY_W-1 -: ptq_pkg::PRI_W]);
	assign rd_id  = ram_rdata[ptq_pkg::ID_W+ptq_pkg::TAG_W-1 -: ptq_pkg::ID_W];
	assign rd_tag = ram_rdata[ptq_pkg::TAG_W-1:0];

	// strict win keeps the earlier slot on a full tie
	assign rd_beats = (rd_pri > best_pri_q) ||
		((rd_pri == best_pri_q) && (rd_id < best_id_q));

	assign sts.full     = (count_q == CW'(QUEUE_DEPTH));
	assign sts.empty    = (count_q == '0);
	assign sts.scan_end = (idx_q == IW'(QUEUE_DEPTH - 1));
	assign sts.more     = (kind_q == ptq_pkg::KIND_VIEW) && !res_last_q;

	assign last = res_last_q;

	always_ff @(posedge clk) begin
		if (cmd.start_op) begin
			kind_q   <= kind;
			pri_in_q <= task_priority;
			tag_in_q <= task_tag;
		end
	end

	// scan control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q        <= '0;
			rd_vld_s1    <= 1'b0;
			best_vld_q   <= 1'b0;
			free_found_q <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.scan_step;
			if (cmd.scan_clear) begin
				idx_q        <= '0;
				best_vld_q   <= 1'b0;
				free_found_q <= 1'b0;
			end else begin
				if (cmd.scan_step) begin
					idx_q <= idx_q + 1'b1;
				end
				if (rd_vld_s1 && cand_s1 && (!best_vld_q || rd_beats)) begin
					best_vld_q <= 1'b1;
				end
				if (rd_vld_s1 && free_s1) begin
					free_found_q <= 1'b1;
				end
			end
		end
	end

	// scan payload
	always_ff @(posedge clk) begin
		if (cmd.scan_step) begin
			idx_s1  <= idx_q;
			cand_s1 <= valid_q[idx_q] && !listed_q[idx_q];
			free_s1 <= !valid_q[idx_q];
		end
		if (rd_vld_s1 && cand_s1 && (!best_vld_q || rd_beats)) begin
			best_idx_q <= idx_s1;
			best_pri_q <= rd_pri;
			best_id_q  <= rd_id;
			best_tag_q <= rd_tag;
		end
		if (rd_vld_s1 && free_s1 && !free_found_q) begin
			free_idx_q <= idx_s1;
		end
	end

	// slot state and result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= '0;
			listed_q     <= '0;
			count_q      <= '0;
			listed_cnt_q <= '0;
			next_id_q    <= ptq_pkg::ID_W'(1);
			res_last_q   <= 1'b0;
		end else begin
			if (cmd.load_quick) begin
				res_last_q <= 1'b1;
			end
			if (cmd.commit) begin
				case (kind_q)
					ptq_pkg::KIND_ADD: begin
						valid_q[free_idx_q] <= 1'b1;
						count_q    <= count_q + 1'b1;
						res_last_q <= 1'b1;
						if (next_id_q == '1) begin
							next_id_q <= ptq_pkg::ID_W'(1);
						end else begin
							next_id_q <= next_id_q + 1'b1;
						end
					end
					ptq_pkg::KIND_EXEC: begin
						valid_q[best_idx_q] <= 1'b0;
						count_q    <= count_q - 1'b1;
						res_last_q <= 1'b1;
					end
					ptq_pkg::KIND_VIEW: begin
						listed_q[best_idx_q] <= 1'b1;
						listed_cnt_q <= listed_cnt_q + 1'b1;
						res_last_q   <= ((listed_cnt_q + CW'(1)) == count_q);
					end
					default: begin
						res_last_q <= 1'b1;
					end
				endcase
			end
			if (cmd.out_done && res_last_q) begin
				listed_q     <= '0;
				listed_cnt_q <= '0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (cmd.load_quick) begin
			status            <= (kind == ptq_pkg::KIND_ADD) ? ptq_pkg::STS_FULL
				: ptq_pkg::STS_EMPTY;
			task_id           <= '0;
			task_priority_out <= '0;
			task_tag_out      <= '0;
		end else if (cmd.commit) begin
			if (kind_q == ptq_pkg::KIND_ADD) begin
				status            <= ptq_pkg::STS_ADDED;
				task_id           <= next_id_q;
				task_priority_out <= pri_in_q;
				task_tag_out      <= tag_in_q;
			end else begin
				status            <= (kind_q == ptq_pkg::KIND_EXEC) ? ptq_pkg::STS_EXECUTED
					: ptq_pkg::STS_LISTED;
				task_id           <= best_id_q;
				task_priority_out <= best_pri_q;
				task_tag_out      <= best_tag_q;
			end
		end
	end

endmodule
`default_nettype wire

// File: hdl/priority_task_queue.sv
// top level of the priority task queue
// A max-priority store of QUEUE_DEPTH tasks. An add beat stores priority and tag
// with the next sequence id (1 to 65535, wrapping to 1) and answers added or full.
// An execute beat removes and returns the best task (highest priority, lower id on
// a tie) or answers empty. A view beat returns every pending task in that order,
// last set on the final one. One item is handled at a time. Slots live in a
// one-read-port ram that is scanned one slot per cycle; add and execute scan every
// slot, then commit and wait for the output handshake, a view scans again for each
// listed task, full and empty beats answer without a scan and wait for the output
// handshake, and ignored beats (kind 3) are accepted and give no output.
`timescale 1ns / 1ps
`default_nettype none
module priority_task_queue #(
	parameter int QUEUE_DEPTH = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  kind,
	input  wire logic signed [15:0] task_priority,
	input  wire logic [15:0] task_tag,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       status,
	output logic [15:0]      task_id,
	output logic signed [15:0] task_priority_out,
	output logic [15:0]      task_tag_out,
	output logic             last
);

	ptq_pkg::ptq_cmd_t cmd;
	ptq_pkg::ptq_sts_t sts;

	ptq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.kind     (kind),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ptq_dpath #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_dpath (
		.clk              (clk),
		.arst_n           (arst_n),
		.kind             (kind),
		.task_priority    (task_priority),
		.task_tag         (task_tag),
		.cmd              (cmd),
		.sts              (sts),
		.status           (status),
		.task_id          (task_id),
		.task_priority_out(task_priority_out),
		.task_tag_out     (task_tag_out),
		.last             (last)
	);

endmodule
`default_nettype wire
